// ===== design/mfde_pkg.sv =====
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants for the monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int WORD_W            = 64;
  localparam int COORD_W           = 12;
  localparam int XR_W              = 11;  // holds a clipped column up to 2047
  localparam int QUEUE_DEPTH       = 2;

  // Input command codes.
  typedef enum logic [2:0] {
    KIND_CLEAR = 3'd0,
    KIND_PIXEL = 3'd1,
    KIND_LINE  = 3'd2,
    KIND_RECT  = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  // Work classes handed from the front to the back.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LINE,
    OP_RECT,
    OP_READ
  } op_t;

  // One queued, classified command.
  typedef struct packed {
    op_t                       op;
    logic                      ink;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] xb;
    logic signed [COORD_W-1:0] yb;
    logic                      sx_neg;
    logic                      sy_neg;
    logic [COORD_W:0]          dx;
    logic [COORD_W:0]          dy;
    logic signed [COORD_W+1:0] err;
    logic [XR_W-1:0]           rx0;
    logic [XR_W-1:0]           rx1;
    logic [WORD_W-1:0]         mask;
    logic [WORD_W-1:0]         inner;
    logic [6:0]                col;
  } cmd_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic busy;
    logic wr_en;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LINE_RD,
    B_LINE_WR,
    B_RECT_RD,
    B_RECT_WR,
    B_READ_RD,
    B_READ_WAIT,
    B_DONE
  } back_state_t;

endpackage

// ===== design/mfde_front.sv =====
// ----------------------------------------------------------------------------
// mfde_front
// Accepts command words, classifies them and precomputes line and rectangle
// setup values before they enter the command queue.
// ----------------------------------------------------------------------------
module mfde_front import mfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_kind,
  input  logic signed [COORD_W-1:0] in_x_start,
  input  logic signed [COORD_W-1:0] in_y_start,
  input  logic signed [COORD_W-1:0] in_x_end,
  input  logic signed [COORD_W-1:0] in_y_end,
  input  logic [COORD_W-1:0]        in_rect_width,
  input  logic [COORD_W-1:0]        in_rect_height,
  input  logic                      in_filled,
  input  logic                      in_ink,
  input  logic [6:0]                in_column,
  input  logic                      q_full,
  output logic                      push,
  output cmd_t                      push_data
);

  localparam logic signed [COORD_W+1:0] SW14 = (COORD_W+2)'(SCREEN_WIDTH);
  localparam logic signed [COORD_W+1:0] SH14 = (COORD_W+2)'(SCREEN_HEIGHT);

  logic signed [COORD_W:0]   dxs, dys;
  logic [COORD_W:0]          dx, dy;
  logic signed [COORD_W+1:0] err0;
  logic signed [COORD_W+1:0] xs14, ys14, xsum, ysum;
  logic signed [COORD_W+1:0] rx_lo, rx_hi, ry_lo, ry_hi, ch;
  logic                      rect_empty;
  logic [WORD_W-1:0]         ones, mask, inner;
  logic [5:0]                ch_m1;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Line deltas and initial error term.
  always_comb begin
    dxs  = $signed({in_x_end[COORD_W-1], in_x_end}) -
           $signed({in_x_start[COORD_W-1], in_x_start});
    dys  = $signed({in_y_end[COORD_W-1], in_y_end}) -
           $signed({in_y_start[COORD_W-1], in_y_start});
    dx   = dxs[COORD_W] ? 13'(-dxs) : 13'(dxs);
    dy   = dys[COORD_W] ? 13'(-dys) : 13'(dys);
    if (dx > dy) begin
      err0 = $signed({2'b00, dx[COORD_W:1]});
    end else begin
      err0 = -$signed({2'b00, dy[COORD_W:1]});
    end
  end

  // Rectangle clipping and column masks.
  always_comb begin
    xs14  = $signed({{2{in_x_start[COORD_W-1]}}, in_x_start});
    ys14  = $signed({{2{in_y_start[COORD_W-1]}}, in_y_start});
    xsum  = xs14 + $signed({2'b00, in_rect_width});
    ysum  = ys14 + $signed({2'b00, in_rect_height});
    rx_lo = xs14[COORD_W+1] ? '0 : xs14;
    ry_lo = ys14[COORD_W+1] ? '0 : ys14;
    rx_hi = (xsum > SW14) ? SW14 : xsum;
    ry_hi = (ysum > SH14) ? SH14 : ysum;
    rect_empty = (rx_hi <= rx_lo) || (ry_hi <= ry_lo);
    ch    = ry_hi - ry_lo;
    ch_m1 = 6'(ch - 14'sd1);
    if (ch >= 14'sd64) begin
      ones = '1;
    end else begin
      ones = (64'd1 << ch[5:0]) - 64'd1;
    end
    mask = ones << ry_lo[5:0];
    if (!in_filled && ch > 14'sd2) begin
      inner = ((64'd1 << ch_m1) | 64'd1) << ry_lo[5:0];
    end else begin
      inner = mask;
    end
  end

  // Build the queue entry.
  always_comb begin
    push_data        = '0;
    push_data.ink    = in_ink;
    push_data.xa     = in_x_start;
    push_data.ya     = in_y_start;
    push_data.xb     = in_x_start;
    push_data.yb     = in_y_start;
    push_data.rx0    = rx_lo[XR_W-1:0];
    push_data.rx1    = XR_W'(rx_hi - 14'sd1);
    push_data.mask   = mask;
    push_data.inner  = inner;
    push_data.col    = in_column;
    case (in_kind)
      KIND_CLEAR: push_data.op = OP_CLEAR;
      KIND_PIXEL: push_data.op = OP_LINE;
      KIND_LINE: begin
        push_data.op     = OP_LINE;
        push_data.xb     = in_x_end;
        push_data.yb     = in_y_end;
        push_data.dx     = dx;
        push_data.dy     = dy;
        push_data.err    = err0;
        push_data.sx_neg = !(in_x_start < in_x_end);
        push_data.sy_neg = !(in_y_start < in_y_end);
      end
      KIND_RECT: push_data.op = rect_empty ? OP_NONE : OP_RECT;
      KIND_READ: push_data.op = OP_READ;
      default:   push_data.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/mfde_queue.sv =====
// ----------------------------------------------------------------------------
// mfde_queue
// Short first-in first-out queue of classified commands between the front
// and the back.
// ----------------------------------------------------------------------------
module mfde_queue import mfde_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  cmd_t                       push_data,
  input  logic                       pop,
  output logic                       q_valid,
  output logic                       q_full,
  output cmd_t                       q_head,
  output logic [$clog2(DEPTH+1)-1:0] q_count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH+1);

  cmd_t            store_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNW-1:0]  cnt_r;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CNW'(DEPTH));
  assign q_head  = store_r[rp_r];
  assign q_count = cnt_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wp_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/mfde_back.sv =====
// ----------------------------------------------------------------------------
// mfde_back
// Executes queued commands against the column store by read-modify-write
// and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module mfde_back import mfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_t              q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_column_bits,
  output back_stat_t        stat
);

  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam logic signed [COORD_W:0] SW13 = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic signed [COORD_W:0] SH13 = (COORD_W+1)'(SCREEN_HEIGHT);

  back_state_t               state_r, state_nxt;
  cmd_t                      cmd_r;
  logic signed [COORD_W-1:0] xa_r, xa_nxt, ya_r, ya_nxt;
  logic signed [COORD_W+1:0] err_r, err_nxt;
  logic [XR_W-1:0]           c_r, c_nxt;
  logic [WORD_W-1:0]         res_r, res_nxt;
  logic                      out_valid_r;
  logic [WORD_W-1:0]         out_bits_r;

  logic [WORD_W-1:0]         mem [SCREEN_WIDTH];
  logic [SCREEN_WIDTH-1:0]   vbits_r;
  logic [WORD_W-1:0]         rd_data_r;
  logic                      rd_vld_r;
  logic [CW-1:0]             rd_addr, wr_addr;
  logic [WORD_W-1:0]         wr_data, old_word, col_mask, pix_bit;
  logic                      wr_en, clr, load_out;
  logic                      at_end, on_scr, step_x, step_y;
  logic signed [COORD_W:0]   xa13, ya13;

  assign out_valid       = out_valid_r;
  assign out_column_bits = out_bits_r;
  assign stat.busy       = (state_r != B_IDLE);
  assign stat.wr_en      = wr_en;

  // Column store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Per-column valid bits: an unwritten column reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vbits_r <= '0;
      end else if (wr_en) begin
        vbits_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vbits_r[rd_addr];
    end
  end

  // Line stepping terms.
  always_comb begin
    xa13     = $signed({xa_r[COORD_W-1], xa_r});
    ya13     = $signed({ya_r[COORD_W-1], ya_r});
    at_end   = (xa_r == cmd_r.xb) && (ya_r == cmd_r.yb);
    on_scr   = !xa_r[COORD_W-1] && !ya_r[COORD_W-1] && (xa13 < SW13) && (ya13 < SH13);
    step_x   = err_r > -$signed({1'b0, cmd_r.dx});
    step_y   = err_r < $signed({1'b0, cmd_r.dy});
    old_word = rd_vld_r ? rd_data_r : '0;
    pix_bit  = 64'd1 << ya_r[5:0];
    col_mask = ((c_r == cmd_r.rx0) || (c_r == cmd_r.rx1)) ? cmd_r.mask : cmd_r.inner;
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt = state_r;
    xa_nxt    = xa_r;
    ya_nxt    = ya_r;
    err_nxt   = err_r;
    c_nxt     = c_r;
    res_nxt   = res_r;
    pop       = 1'b0;
    clr       = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = xa_r[CW-1:0];
    wr_data   = cmd_r.ink ? (old_word | pix_bit) : (old_word & ~pix_bit);
    load_out  = 1'b0;
    case (state_r)
      B_READ_RD, B_READ_WAIT: rd_addr = CW'(cmd_r.col);
      B_RECT_RD, B_RECT_WR:   rd_addr = c_r[CW-1:0];
      default:                rd_addr = xa_r[CW-1:0];
    endcase

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          res_nxt = '0;
          xa_nxt  = q_head.xa;
          ya_nxt  = q_head.ya;
          err_nxt = q_head.err;
          c_nxt   = q_head.rx0;
          unique case (q_head.op)
            OP_CLEAR: begin
              clr       = 1'b1;
              state_nxt = B_DONE;
            end
            OP_LINE:  state_nxt = B_LINE_RD;
            OP_RECT:  state_nxt = B_RECT_RD;
            OP_READ:  state_nxt = B_READ_RD;
            default:  state_nxt = B_DONE;
          endcase
        end
      end
      B_LINE_RD, B_LINE_WR: begin
        // An off-screen pixel is skipped without touching the store.
        if (state_r == B_LINE_RD && on_scr) begin
          state_nxt = B_LINE_WR;
        end else begin
          wr_en = (state_r == B_LINE_WR);
          if (at_end) begin
            state_nxt = B_DONE;
          end else begin
            state_nxt = B_LINE_RD;
            err_nxt   = err_r - (step_x ? $signed({1'b0, cmd_r.dy}) : '0)
                              + (step_y ? $signed({1'b0, cmd_r.dx}) : '0);
            if (step_x) begin
              xa_nxt = cmd_r.sx_neg ? xa_r - 1'b1 : xa_r + 1'b1;
            end
            if (step_y) begin
              ya_nxt = cmd_r.sy_neg ? ya_r - 1'b1 : ya_r + 1'b1;
            end
          end
        end
      end
      B_RECT_RD: state_nxt = B_RECT_WR;
      B_RECT_WR: begin
        wr_en   = 1'b1;
        wr_addr = c_r[CW-1:0];
        wr_data = cmd_r.ink ? (old_word | col_mask) : (old_word & ~col_mask);
        if (c_r == cmd_r.rx1) begin
          state_nxt = B_DONE;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = B_RECT_RD;
        end
      end
      B_READ_RD: state_nxt = B_READ_WAIT;
      B_READ_WAIT: begin
        if ({1'b0, cmd_r.col} < 8'(SCREEN_WIDTH > 255 ? 255 : SCREEN_WIDTH)
            || SCREEN_WIDTH > 128) begin
          res_nxt = old_word;
        end
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_r) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= q_head;
    end
    xa_r  <= xa_nxt;
    ya_r  <= ya_nxt;
    err_r <= err_nxt;
    c_r   <= c_nxt;
    res_r <= res_nxt;
    if (load_out) begin
      out_bits_r <= res_r;
    end
  end

endmodule

// ===== design/mono_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// One-bit-per-pixel column store with a line, rectangle and pixel engine.
// ----------------------------------------------------------------------------
// Every command returns exactly one word on the out_ channel; it is the column
// contents for a read and zero otherwise. Commands queue two deep behind the
// input, and the back end runs one command at a time against a column store
// with one write and one registered read port by read-modify-write: each
// written pixel or column is read and then written, and a clipped-off line
// pixel is skipped without a write. The store is empty after reset and after
// a clear, with no clearing pass.
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_kind,
  input  logic signed [COORD_W-1:0] in_x_start,
  input  logic signed [COORD_W-1:0] in_y_start,
  input  logic signed [COORD_W-1:0] in_x_end,
  input  logic signed [COORD_W-1:0] in_y_end,
  input  logic [COORD_W-1:0]        in_rect_width,
  input  logic [COORD_W-1:0]        in_rect_height,
  input  logic                      in_filled,
  input  logic                      in_ink,
  input  logic [6:0]                in_column,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WORD_W-1:0]         out_column_bits
);

  localparam int CNW = $clog2(QUEUE_DEPTH+1);

  logic           push, pop, q_valid, q_full;
  cmd_t           push_data, q_head;
  logic [CNW-1:0] q_count;
  back_stat_t     stat;

  mfde_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_filled      (in_filled),
    .in_ink         (in_ink),
    .in_column      (in_column),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  mfde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_head    (q_head),
    .q_count   (q_count)
  );

  mfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column_bits (out_column_bits),
    .stat            (stat)
  );

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNW'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // An accepted word is visible next cycle in the queue or in the back end.
  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (q_count != '0) || stat.busy)
    else $error("accepted command word lost");

  // The store is written only while a command is being executed.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.wr_en |-> stat.busy)
    else $error("store written while idle");

endmodule

// ===== tb/sv/mono_framebuffer_draw_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_tb
// Self-checking bench for the frame buffer draw engine. A behavioral copy of
// the column store predicts the word returned for every command; directed
// tests cover clipping corners, lines and outlines, then random drawing runs
// with column read-backs exercise the store under random stalls.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_tb;
  import mfde_pkg::*;

  localparam int SCR_W = 128;
  localparam int SCR_H = 64;
  localparam int CYCLE_LIMIT = 40000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic signed [COORD_W-1:0] in_x_start = '0;
  logic signed [COORD_W-1:0] in_y_start = '0;
  logic signed [COORD_W-1:0] in_x_end = '0;
  logic signed [COORD_W-1:0] in_y_end = '0;
  logic [COORD_W-1:0] in_rect_width = '0;
  logic [COORD_W-1:0] in_rect_height = '0;
  logic in_filled = 1'b0;
  logic in_ink = 1'b0;
  logic [6:0] in_column = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] out_column_bits;

  logic [WORD_W-1:0] model_store [SCR_W];
  logic [WORD_W-1:0] expected_words [$];
  int errors = 0;
  int cycle_count = 0;
  bit stall_free = 1'b0;

  mono_framebuffer_draw_engine dut (.*);

  // Clock, period 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on total run time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Model helpers: one pixel, one masked column write.
  function automatic void model_pixel(int x, int y, bit ink);
    if (x < 0 || y < 0 || x >= SCR_W || y >= SCR_H) return;
    model_store[x][y] = ink;
  endfunction

  function automatic void model_col(int x, logic [WORD_W-1:0] mask, bit ink);
    model_store[x] = (model_store[x] & ~mask) | (ink ? mask : '0);
  endfunction

  // Bresenham line, both endpoints drawn, each pixel clipped alone.
  function automatic void model_line(int xa, int ya, int xb, int yb, bit ink);
    int dx, dy, sx, sy, err, prev;
    dx = (xb > xa) ? xb - xa : xa - xb;
    dy = (yb > ya) ? yb - ya : ya - yb;
    sx = (xa < xb) ? 1 : -1;
    sy = (ya < yb) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    forever begin
      model_pixel(xa, ya, ink);
      if (xa == xb && ya == yb) break;
      prev = err;
      if (prev > -dx) begin
        err -= dy;
        xa += sx;
      end
      if (prev < dy) begin
        err += dx;
        ya += sy;
      end
    end
  endfunction

  // Clipped rectangle, filled or outline.
  function automatic void model_rect(int x, int y, int w, int h, bit fill, bit ink);
    int x0, y0, x1, y1, cw, ch;
    logic [WORD_W-1:0] mask, inner;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > SCR_W) ? SCR_W : x + w;
    y1 = (y + h > SCR_H) ? SCR_H : y + h;
    if (x1 <= x0 || y1 <= y0) return;
    cw = x1 - x0;
    ch = y1 - y0;
    if (ch >= 64) mask = '1;
    else mask = ((64'd1 << ch) - 64'd1) << y0;
    inner = mask;
    if (!fill && ch > 2) inner = ((64'd1 << (ch - 1)) | 64'd1) << y0;
    model_col(x0, mask, ink);
    if (cw > 1) model_col(x1 - 1, mask, ink);
    for (int c = x0 + 1; c < x1 - 1; c++) model_col(c, inner, ink);
  endfunction

  // Predict the returned word for one command and update the model store.
  function automatic logic [WORD_W-1:0] predict_word(logic [2:0] kind,
      int xs, int ys, int xe, int ye, int rw, int rh, bit fill, bit ink,
      logic [6:0] col);
    case (kind)
      KIND_CLEAR: foreach (model_store[i]) model_store[i] = '0;
      KIND_PIXEL: model_pixel(xs, ys, ink);
      KIND_LINE:  model_line(xs, ys, xe, ye, ink);
      KIND_RECT:  model_rect(xs, ys, rw, rh, fill, ink);
      KIND_READ:  return model_store[col];
      default: ;
    endcase
    return '0;
  endfunction

  // Send one command word after a random gap and queue its prediction.
  // Valid drops only when a gap follows, so back-to-back words keep it high.
  task automatic send_cmd(logic [2:0] kind, logic [11:0] xs, logic [11:0] ys,
      logic [11:0] xe, logic [11:0] ye, logic [11:0] rw, logic [11:0] rh,
      bit fill, bit ink, logic [6:0] col);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_rect_width <= rw;
    in_rect_height <= rh;
    in_filled <= fill;
    in_ink <= ink;
    in_column <= col;
    expected_words.push_back(predict_word(kind, $signed(xs), $signed(ys), $signed(xe),
        $signed(ye), int'(rw), int'(rh), fill, ink, col));
    // Ready is settled mid-cycle, so it is checked there for the coming edge.
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic read_col(int c);
    send_cmd(KIND_READ, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
        12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom), c[6:0]);
  endtask

  task automatic read_all_cols();
    for (int c = 0; c < SCR_W; c++) read_col(c);
  endtask

  // Result side: random stall per word, compare against oldest prediction.
  initial begin
    int stall;
    logic [WORD_W-1:0] got_w;
    forever begin
      stall = stall_free ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (out_valid !== 1'b1) @(negedge clk);
      got_w = out_column_bits;
      @(posedge clk);
      if (expected_words.size() == 0) begin
        $error("unexpected word: column_bits actual %h", got_w);
        errors++;
      end else begin
        logic [WORD_W-1:0] exp_w;
        exp_w = expected_words.pop_front();
        if (got_w !== exp_w) begin
          $error("column_bits mismatch: expected %h actual %h", exp_w, got_w);
          errors++;
        end
      end
    end
  end

  // Edges of the screen, clipping and extreme fields.
  task automatic test_pixels_and_edges();
    send_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    send_cmd(KIND_PIXEL, 127, 63, 0, 0, 0, 0, 0, 1, 0);
    send_cmd(KIND_PIXEL, -2048, 5, 0, 0, 0, 0, 0, 1, 0);
    send_cmd(KIND_PIXEL, 5, 2047, 0, 0, 0, 0, 0, 1, 0);
    send_cmd(KIND_PIXEL, 128, 64, 0, 0, 0, 0, 0, 1, 0);
    read_col(0);
    read_col(127);
    send_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    read_col(0);
    send_cmd(3'd5, 1, 1, 1, 1, 1, 1, 1, 1, 1);
    send_cmd(3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1, 1, 7'h7F);
  endtask

  // Lines: steep, shallow, reversed, clipped and a single point.
  task automatic test_lines();
    send_cmd(KIND_LINE, 0, 0, 127, 63, 0, 0, 0, 1, 0);
    send_cmd(KIND_LINE, 127, 0, 0, 63, 0, 0, 0, 1, 0);
    send_cmd(KIND_LINE, -20, 70, 140, -10, 0, 0, 0, 1, 0);
    send_cmd(KIND_LINE, 10, 10, 10, 10, 0, 0, 0, 1, 0);
    send_cmd(KIND_LINE, 30, 60, 33, 2, 0, 0, 0, 0, 0);
    read_all_cols();
  endtask

  // Rectangles: outline heights 1 to 3, full height, empty and huge clipped.
  task automatic test_rects();
    send_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_RECT, 2, 2, 0, 0, 10, 1, 0, 1, 0);
    send_cmd(KIND_RECT, 20, 5, 0, 0, 10, 2, 0, 1, 0);
    send_cmd(KIND_RECT, 40, 10, 0, 0, 10, 3, 0, 1, 0);
    send_cmd(KIND_RECT, 60, 0, 0, 0, 1, 64, 0, 1, 0);
    send_cmd(KIND_RECT, -2048, -2048, 0, 0, 4095, 4095, 0, 1, 0);
    send_cmd(KIND_RECT, 5, 5, 0, 0, 0, 10, 1, 1, 0);
    send_cmd(KIND_RECT, 5, 5, 0, 0, 10, 0, 1, 1, 0);
    send_cmd(KIND_RECT, 100, 30, 0, 0, 4095, 4095, 1, 0, 0);
    read_all_cols();
  endtask

  // Random coordinates biased near the screen, with full-range noise.
  function automatic logic [11:0] rand_coord(int span);
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    return 12'(int'($urandom_range(0, span + 40)) - 20);
  endfunction

  task automatic test_random();
    logic [2:0] kind;
    int pick;
    for (int n = 0; n < 600; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) kind = KIND_CLEAR;
      else if (pick < 20) kind = KIND_PIXEL;
      else if (pick < 40) kind = KIND_LINE;
      else if (pick < 55) kind = KIND_RECT;
      else if (pick < 97) kind = KIND_READ;
      else kind = 3'($urandom_range(5, 7));
      // Half the time toggle stalls off to get back-to-back stretches.
      if (n % 100 == 0) stall_free = $urandom_range(0, 1);
      send_cmd(kind, rand_coord(SCR_W), rand_coord(SCR_H), rand_coord(SCR_W),
          rand_coord(SCR_H),
          ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 70)),
          ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 70)),
          1'($urandom), 1'($urandom), 7'($urandom));
    end
    stall_free = 1'b0;
    read_all_cols();
  endtask

  initial begin
    foreach (model_store[i]) model_store[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pixels_and_edges();
    test_lines();
    test_rects();
    test_random();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
